// ===== rtl/core/dss_pkg.sv =====
package dss_pkg;

  // default geometry
  localparam int NUM_SETS_DEF = 2048;
  localparam int NUM_WAYS_DEF = 16;

  // item field widths
  localparam int SET_FLD_W  = 11;
  localparam int WAY_FLD_W  = 4;
  localparam int ADDR_W     = 48;
  localparam int LINE_W     = 42;
  localparam int RND_W      = 5;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 8;

  // configuration
  localparam int CFG_DATA_W = 11;
  localparam logic REG_LEADER_SETS   = 1'b0;
  localparam logic REG_STREAM_WINDOW = 1'b1;
  localparam logic [10:0] LEADER_SETS_RST   = 11'd64;
  localparam logic [3:0]  STREAM_WINDOW_RST = 4'd8;

  // item kinds
  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // ages and selector
  localparam logic [1:0] AGE_MAX  = 2'd3;
  localparam logic [1:0] AGE_FAR  = 2'd2;
  localparam logic [1:0] AGE_NEAR = 2'd0;
  localparam logic [1:0] REUSE_RST = 2'd1;
  localparam logic [9:0] PSEL_MID = 10'd512;
  localparam logic [9:0] PSEL_TOP = 10'd1023;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } dss_state_t;

  // per-set stream detector entry
  typedef struct packed {
    logic [LINE_W-1:0] last_line;
    logic [1:0]        stride_run;
    logic              stream_flag;
    logic [3:0]        window_left;
  } dss_stream_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } dss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
  } dss_stat_t;

  // 4-bit program-counter signature
  function automatic logic [3:0] sig_of(input logic [ADDR_W-1:0] pc);
    sig_of = pc[3:0] ^ pc[7:4] ^ pc[11:8];
  endfunction

endpackage

// ===== rtl/core/drrip_ship_stream_replacement_core.sv =====
// Cache replacement policy: DRRIP set dueling, a 16-entry signature reuse
// table and a per-set sequential stream detector with a bypass window.
// in channel: one transaction per request; in_tuser selects victim request (0)
// or access update (1). out channel: exactly one result per request.
// cfg port: cfg_we writes register cfg_index (0 leader_sets, 1 stream_window)
// with cfg_data; write only while no request is outstanding.
// Each request is a read-modify-write of one set: set memories are read at
// acceptance and written back in the cycle after, so a new request is not
// accepted while the last one is still being written back. The result is
// registered in the write-back step and held in out_tdata until taken.
// After reset the block sweeps its set memories to their reset values, one
// set per cycle, with in_tready low; cfg writes still apply.
// When the receiver stalls, the result waits in the output register; the next
// request is accepted only once that slot is empty or being taken.
// NUM_SETS must be a power of two.
module drrip_ship_stream_replacement_core #(
  parameter int NUM_SETS = dss_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = dss_pkg::NUM_WAYS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // set_index[10:0], way_index[14:11], physical_address[62:15],
  // program_counter[110:63], was_hit[111], random_value[116:112], zero fill
  input  logic [119:0] in_tdata,
  // kind[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // victim_way[3:0], insert_age[5:4], bypassing[6], zero fill
  output logic [7:0]   out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [10:0]  cfg_data
);
  import dss_pkg::*;

  dss_cmd_t  cmd;
  dss_stat_t stat;

  dss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .stat(stat)
  );

  dss_datapath #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_datapath (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .stat(stat),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_tdata(out_tdata)
  );

endmodule

// ===== rtl/core/dss_ram.sv =====
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/dss_ctrl.sv =====
module dss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dss_pkg::dss_cmd_t cmd,
  input  dss_pkg::dss_stat_t stat
);
  import dss_pkg::*;

  dss_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       ready;

  // state and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // take an item only when idle and the result slot frees by the end
  assign ready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid && ready) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_tready  = ready;
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/dss_datapath.sv =====
module dss_datapath #(
  parameter int NUM_SETS = dss_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = dss_pkg::NUM_WAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dss_pkg::dss_cmd_t                 cmd,
  output dss_pkg::dss_stat_t                stat,
  input  logic                              in_tuser,
  input  logic [dss_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [dss_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import dss_pkg::*;

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int CMP_W = ((SET_W > SET_FLD_W) ? SET_W : SET_FLD_W) + 2;
  localparam int AGE_ROW_W = 2 * NUM_WAYS;
  localparam int SIG_ROW_W = 4 * NUM_WAYS;
  localparam int ST_W = $bits(dss_stream_t);

  // configuration registers
  logic [10:0] leader_sets_r;
  logic [3:0]  stream_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_sets_r   <= LEADER_SETS_RST;
      stream_window_r <= STREAM_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEADER_SETS:   leader_sets_r   <= cfg_data;
        REG_STREAM_WINDOW: stream_window_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // reduce a way field modulo the way count
  function automatic logic [WAY_W-1:0] way_mod(input logic [WAY_FLD_W-1:0] v);
    logic [WAY_FLD_W:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (t >= (WAY_FLD_W+1)'(NUM_WAYS)) begin
        t = t - (WAY_FLD_W+1)'(NUM_WAYS);
      end
    end
    way_mod = WAY_W'(t);
  endfunction

  // unpack the input transaction (set count is a power of two)
  logic [SET_W-1:0]  in_set;
  logic [WAY_W-1:0]  in_way;
  assign in_set = SET_W'(in_tdata[10:0]);
  assign in_way = way_mod(in_tdata[14:11]);

  // captured item
  logic              kind_r;
  logic [SET_W-1:0]  set_r;
  logic [WAY_W-1:0]  way_r;
  logic [LINE_W-1:0] line_r;
  logic [3:0]        sig_r;
  logic              hit_r;
  logic [RND_W-1:0]  rnd_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_tuser;
      set_r  <= in_set;
      way_r  <= in_way;
      line_r <= in_tdata[62:21];
      sig_r  <= sig_of(in_tdata[110:63]);
      hit_r  <= in_tdata[111];
      rnd_r  <= in_tdata[116:112];
    end
  end

  // clearing pass counter
  logic [SET_W-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end
  assign stat.clr_last = (clr_cnt_r == SET_W'(NUM_SETS - 1));

  // set memories
  logic [AGE_ROW_W-1:0] age_row, age_new;
  logic [SIG_ROW_W-1:0] sig_row, sig_new;
  logic [ST_W-1:0]      st_raw;
  dss_stream_t          st_old, st_new;
  logic [SET_W-1:0]     waddr;
  logic [AGE_ROW_W-1:0] age_wdata;
  logic [SIG_ROW_W-1:0] sig_wdata;
  logic [ST_W-1:0]      st_wdata;
  logic                 row_we, st_we;

  assign waddr     = cmd.clear ? clr_cnt_r : set_r;
  assign row_we    = cmd.clear || cmd.exec;
  assign st_we     = cmd.clear || (cmd.exec && (kind_r == KIND_UPDATE));
  assign age_wdata = cmd.clear ? {AGE_ROW_W{1'b1}} : age_new;
  assign sig_wdata = cmd.clear ? '0 : sig_new;
  assign st_wdata  = cmd.clear ? '0 : ST_W'(st_new);
  assign st_old    = dss_stream_t'(st_raw);

  dss_ram #(.WIDTH(AGE_ROW_W), .DEPTH(NUM_SETS)) u_age_ram (
    .clk(clk), .we(row_we), .waddr(waddr), .wdata(age_wdata),
    .raddr(in_set), .rdata(age_row)
  );

  dss_ram #(.WIDTH(SIG_ROW_W), .DEPTH(NUM_SETS)) u_sig_ram (
    .clk(clk), .we(row_we), .waddr(waddr), .wdata(sig_wdata),
    .raddr(in_set), .rdata(sig_row)
  );

  dss_ram #(.WIDTH(ST_W), .DEPTH(NUM_SETS)) u_stream_ram (
    .clk(clk), .we(st_we), .waddr(waddr), .wdata(st_wdata),
    .raddr(in_set), .rdata(st_raw)
  );

  // reuse counters and policy selector
  logic [1:0] reuse_r [16];
  logic [9:0] psel_r;

  // victim search: first age 3, else age all and search again
  logic [AGE_ROW_W-1:0] aged_row;
  logic                 found1, found2;
  logic [WAY_W-1:0]     w1, w2, victim;

  always_comb begin
    found1 = 1'b0;
    found2 = 1'b0;
    w1     = '0;
    w2     = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      aged_row[2*i +: 2] = (age_row[2*i +: 2] == AGE_MAX) ? AGE_MAX
                                                          : age_row[2*i +: 2] + 2'd1;
    end
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (age_row[2*i +: 2] == AGE_MAX) begin
        found1 = 1'b1;
        w1     = WAY_W'(i);
      end
      if (aged_row[2*i +: 2] == AGE_MAX) begin
        found2 = 1'b1;
        w2     = WAY_W'(i);
      end
    end
    victim = found1 ? w1 : (found2 ? w2 : '0);
  end

  // stride tracking
  logic       step;
  logic [1:0] run_n;
  logic       flag_n;
  logic [3:0] win_n;
  logic       inwin_old, inwin_new;

  always_comb begin
    step = (st_old.last_line != '0) &&
           (({1'b0, line_r} == {1'b0, st_old.last_line} + 1'b1) ||
            ({1'b0, line_r} + 1'b1 == {1'b0, st_old.last_line}));
    if (step) begin
      run_n  = (st_old.stride_run == 2'd3) ? 2'd3 : st_old.stride_run + 2'd1;
      flag_n = st_old.stream_flag;
      win_n  = st_old.window_left;
      if (run_n == 2'd3 && !st_old.stream_flag) begin
        flag_n = 1'b1;
        win_n  = stream_window_r;
      end
    end else begin
      run_n  = 2'd0;
      flag_n = 1'b0;
      win_n  = 4'd0;
    end
    if (flag_n && win_n != 4'd0) begin
      win_n = win_n - 4'd1;
    end
    st_new.last_line   = line_r;
    st_new.stride_run  = run_n;
    st_new.stream_flag = flag_n;
    st_new.window_left = win_n;
    inwin_old = st_old.stream_flag && (st_old.window_left != 4'd0);
    inwin_new = flag_n && (win_n != 4'd0);
  end

  // leader sets and insertion age
  logic       srrip_lead, brrip_lead, srrip_pick;
  logic [1:0] ins;
  logic [3:0] old_sig;

  always_comb begin
    srrip_lead = CMP_W'(set_r) < CMP_W'(leader_sets_r);
    brrip_lead = !srrip_lead &&
                 (CMP_W'(set_r) + CMP_W'(leader_sets_r) >= CMP_W'(NUM_SETS));
    srrip_pick = srrip_lead || (!brrip_lead && (psel_r >= PSEL_MID));
    if (inwin_new) begin
      ins = AGE_MAX;
    end else begin
      if (srrip_pick) begin
        ins = AGE_FAR;
      end else begin
        ins = (rnd_r == '0) ? AGE_FAR : AGE_MAX;
      end
      if (reuse_r[sig_r] >= 2'd2) begin
        ins = AGE_NEAR;
      end
    end
    old_sig = sig_row[4*way_r +: 4];
  end

  // row write-back
  always_comb begin
    age_new = age_row;
    sig_new = sig_row;
    if (kind_r == KIND_VICTIM) begin
      age_new = found1 ? age_row : aged_row;
    end else if (hit_r) begin
      age_new[2*way_r +: 2] = AGE_NEAR;
    end else begin
      age_new[2*way_r +: 2] = ins;
      sig_new[4*way_r +: 4] = sig_r;
    end
  end

  // training
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        reuse_r[i] <= REUSE_RST;
      end
      psel_r <= PSEL_MID;
    end else if (cmd.exec && (kind_r == KIND_UPDATE)) begin
      if (hit_r) begin
        if (reuse_r[old_sig] != 2'd3) begin
          reuse_r[old_sig] <= reuse_r[old_sig] + 2'd1;
        end
        if (srrip_lead && psel_r != PSEL_TOP) begin
          psel_r <= psel_r + 10'd1;
        end
        if (brrip_lead && psel_r != 10'd0) begin
          psel_r <= psel_r - 10'd1;
        end
      end else if (reuse_r[sig_r] != 2'd0 && ins == AGE_MAX) begin
        reuse_r[sig_r] <= reuse_r[sig_r] - 2'd1;
      end
    end
  end

  // result register
  logic [3:0] res_way_r;
  logic [1:0] res_age_r;
  logic       res_byp_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (kind_r == KIND_VICTIM) begin
        res_way_r <= 4'(victim);
        res_age_r <= 2'd0;
        res_byp_r <= inwin_old;
      end else begin
        res_way_r <= 4'd0;
        res_age_r <= hit_r ? 2'd0 : ins;
        res_byp_r <= inwin_new;
      end
    end
  end

  assign out_tdata = {1'b0, res_byp_r, res_age_r, res_way_r};

endmodule
